// ===== design/sha256_streaming_hash_unit_macros.svh =====
// Assertion macros of the streaming hash unit, used by its top level.
`ifndef SHA256_STREAMING_HASH_UNIT_MACROS_SVH
`define SHA256_STREAMING_HASH_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising clock edge outside reset.
`define SHA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// Next-cycle implication, checked at every rising clock edge outside reset.
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define SHA_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define SHA_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ===== design/sha256s_pkg.sv =====
// Types, constants and round functions of the streaming hash unit.
`default_nettype none
package sha256s_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned BLOCK_WORDS = 16;
   localparam int unsigned HASH_WORDS  = 8;
   localparam int unsigned ROUNDS      = 64;
   localparam int unsigned FILL_W      = 6;
   localparam int unsigned TOTAL_W     = 61;
   localparam int unsigned LEN_WORD_HI = 14;
   localparam int unsigned PAD_LIMIT   = 56;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_OVERFLOW = 1'b1;

   localparam logic [7:0] PAD_MARK = 8'h80;

   localparam logic [TOTAL_W-1:0] MAX_BYTES = {TOTAL_W{1'b1}};

   typedef logic [WORD_W-1:0] word_type;
   typedef word_type [BLOCK_WORDS-1:0] block_type;
   typedef word_type [HASH_WORDS-1:0] hash_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_RUN,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      PH_MESSAGE,
      PH_PAD_FIRST,
      PH_PAD_LAST
   } phase_type;

   // Control from the sequencer to the round engine.
   typedef struct packed {
      logic start;
      logic init;
   } core_ctrl_type;

   // Status from the round engine to the sequencer.
   typedef struct packed {
      logic busy;
      logic done;
   } core_stat_type;

   localparam hash_type INIT_H = '{
      32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
      32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

   localparam word_type ROUND_K [ROUNDS] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

   function automatic word_type big_sigma0(input word_type x);
      return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
   endfunction

   function automatic word_type big_sigma1(input word_type x);
      return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
   endfunction

   function automatic word_type small_sigma0(input word_type x);
      return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
   endfunction

   function automatic word_type small_sigma1(input word_type x);
      return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
   endfunction

endpackage
`default_nettype wire

// ===== design/sha256s_chan_if.sv =====
// Request and response channel interfaces of the streaming hash unit.
`default_nettype none
interface sha256s_req_if;
   logic       valid;
   logic       ready;
   logic       op;
   logic [7:0] data_byte;
   modport source (output valid, output op, output data_byte, input ready);
   modport sink (input valid, input op, input data_byte, output ready);
endinterface

interface sha256s_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_word;
   logic        status;
   modport source (output valid, output digest_word, output word_index,
                   output last_word, output status, input ready);
   modport sink (input valid, input digest_word, input word_index,
                 input last_word, input status, output ready);
endinterface
`default_nettype wire

// ===== design/sha256_streaming_hash_unit.sv =====
// Top level of the streaming hash unit: byte packing, padding and digest output.
//
//   channel   dir   handshake     payload
//   req_chan  in    valid/ready   op, data_byte
//   rsp_chan  out   valid/ready   digest_word, word_index, last_word, status
//
// An absorb beat is taken while the unit is idle; the beat that fills a 64-byte block
// also starts the round engine (one round a cycle over a single round unit).
// A finish beat runs one or two compressions of padded blocks, then eight response beats.
// Reset is synchronous; the unit is ready the cycle after reset falls.
// A stalled response holds the engine; no request is taken until all eight words leave.
`default_nettype none
`include "sha256_streaming_hash_unit_macros.svh"
module sha256_streaming_hash_unit (
   input  wire           clock,
   input  wire           reset,
   sha256s_req_if.sink   req_chan,
   sha256s_rsp_if.source rsp_chan
);

   localparam int unsigned FW = sha256s_pkg::FILL_W;

   sha256s_pkg::state_type     state_ff, state_in;
   sha256s_pkg::phase_type     phase_ff, phase_in;
   sha256s_pkg::block_type     buf_ff, buf_in;
   logic [FW-1:0]              fill_ff, fill_in;
   logic [sha256s_pkg::TOTAL_W-1:0] total_ff, total_in;
   logic                       ovf_ff, ovf_in;
   logic                       two_ff, two_in;
   logic [2:0]                 idx_ff, idx_in;

   sha256s_pkg::core_ctrl_type ctrl;
   sha256s_pkg::core_stat_type stat;
   sha256s_pkg::hash_type      chain;

   logic                       req_fire, rsp_fire;
   logic [63:0]                len_bits;
   sha256s_pkg::block_type     pad_blk;

   assign req_fire = req_chan.valid && req_chan.ready;
   assign rsp_fire = rsp_chan.valid && rsp_chan.ready;
   assign len_bits = {total_ff, 3'b000};

   // First padded block: kept bytes, the marker byte, zeros and maybe the length.
   always_comb begin
      for (int j = 0; j < sha256s_pkg::BLOCK_WORDS; j++) begin
         for (int b = 0; b < 4; b++) begin
            if (FW'(4 * j + b) < fill_ff) begin
               pad_blk[j][8*(3-b) +: 8] = buf_ff[j][8*(3-b) +: 8];
            end else if (FW'(4 * j + b) == fill_ff) begin
               pad_blk[j][8*(3-b) +: 8] = sha256s_pkg::PAD_MARK;
            end else begin
               pad_blk[j][8*(3-b) +: 8] = 8'h00;
            end
         end
      end
      if (fill_ff < FW'(sha256s_pkg::PAD_LIMIT)) begin
         pad_blk[sha256s_pkg::LEN_WORD_HI]     = len_bits[63:32];
         pad_blk[sha256s_pkg::LEN_WORD_HI + 1] = len_bits[31:0];
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         sha256s_pkg::ST_IDLE: begin
            if (req_fire && (req_chan.op == sha256s_pkg::OP_FINISH
                             || (!ovf_ff && total_ff != sha256s_pkg::MAX_BYTES
                                 && fill_ff == FW'(63)))) begin
               state_in = sha256s_pkg::ST_START;
            end
         end
         sha256s_pkg::ST_START: state_in = sha256s_pkg::ST_RUN;
         sha256s_pkg::ST_RUN: begin
            if (stat.done) begin
               if (phase_ff == sha256s_pkg::PH_MESSAGE) begin
                  state_in = sha256s_pkg::ST_IDLE;
               end else if (two_ff) begin
                  state_in = sha256s_pkg::ST_START;
               end else begin
                  state_in = sha256s_pkg::ST_EMIT;
               end
            end
         end
         sha256s_pkg::ST_EMIT: begin
            if (rsp_fire && idx_ff == 3'd7) begin
               state_in = sha256s_pkg::ST_IDLE;
            end
         end
         default: state_in = sha256s_pkg::ST_IDLE;
      endcase
   end

   // Datapath updates and control outputs.
   always_comb begin
      phase_in   = phase_ff;
      buf_in     = buf_ff;
      fill_in    = fill_ff;
      total_in   = total_ff;
      ovf_in     = ovf_ff;
      two_in     = two_ff;
      idx_in     = idx_ff;
      ctrl.start = 1'b0;
      ctrl.init  = 1'b0;
      case (state_ff)
         sha256s_pkg::ST_IDLE: begin
            if (req_fire && req_chan.op == sha256s_pkg::OP_ABSORB) begin
               if (ovf_ff || total_ff == sha256s_pkg::MAX_BYTES) begin
                  ovf_in = 1'b1;
               end else begin
                  if (fill_ff[1:0] == 2'd0) begin
                     buf_in[fill_ff[FW-1:2]] = {req_chan.data_byte, 24'h0};
                  end else begin
                     buf_in[fill_ff[FW-1:2]][8*(3-fill_ff[1:0]) +: 8] = req_chan.data_byte;
                  end
                  fill_in  = fill_ff + 1'b1;
                  total_in = total_ff + 1'b1;
                  phase_in = sha256s_pkg::PH_MESSAGE;
               end
            end else if (req_fire) begin
               buf_in   = pad_blk;
               two_in   = fill_ff >= FW'(sha256s_pkg::PAD_LIMIT);
               phase_in = sha256s_pkg::PH_PAD_FIRST;
            end
         end
         sha256s_pkg::ST_START: ctrl.start = 1'b1;
         sha256s_pkg::ST_RUN: begin
            if (stat.done && phase_ff != sha256s_pkg::PH_MESSAGE && two_ff) begin
               buf_in = '0;
               buf_in[sha256s_pkg::LEN_WORD_HI]     = len_bits[63:32];
               buf_in[sha256s_pkg::LEN_WORD_HI + 1] = len_bits[31:0];
               two_in   = 1'b0;
               phase_in = sha256s_pkg::PH_PAD_LAST;
            end
            idx_in = '0;
         end
         sha256s_pkg::ST_EMIT: begin
            if (rsp_fire) begin
               idx_in = idx_ff + 1'b1;
               if (idx_ff == 3'd7) begin
                  ctrl.init = 1'b1;
                  fill_in   = '0;
                  total_in  = '0;
                  ovf_in    = 1'b0;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sha256s_pkg::ST_IDLE;
         phase_ff <= sha256s_pkg::PH_MESSAGE;
         fill_ff  <= '0;
         total_ff <= '0;
         ovf_ff   <= 1'b0;
         two_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         fill_ff  <= fill_in;
         total_ff <= total_in;
         ovf_ff   <= ovf_in;
         two_ff   <= two_in;
         idx_ff   <= idx_in;
      end
      buf_ff <= buf_in;
   end

   sha256s_core u_core (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .block (buf_ff),
      .stat  (stat),
      .chain (chain)
   );

   // Handshake and response payload.
   assign req_chan.ready       = (state_ff == sha256s_pkg::ST_IDLE);
   assign rsp_chan.valid       = (state_ff == sha256s_pkg::ST_EMIT);
   assign rsp_chan.digest_word = chain[idx_ff];
   assign rsp_chan.word_index  = idx_ff;
   assign rsp_chan.last_word   = (idx_ff == 3'd7);
   assign rsp_chan.status      = ovf_ff ? sha256s_pkg::STATUS_OVERFLOW
                                        : sha256s_pkg::STATUS_OK;

   // The engine is started only while it is idle.
   `SHA_ASSERT_SAME(a_start_idle, clock, reset, ctrl.start, !stat.busy, "start while busy")
   // Digest words leave only once the engine has finished.
   `SHA_ASSERT_SAME(a_emit_idle, clock, reset, rsp_chan.valid, !stat.busy && !req_chan.ready,
                    "response while busy")
   // The last digest word returns the unit to its initial chaining value.
   `SHA_ASSERT_NEXT(a_reinit, clock, reset, rsp_fire && rsp_chan.last_word,
                    chain[0] == sha256s_pkg::INIT_H[0] && fill_ff == '0, "no reinit")

endmodule
`default_nettype wire

// ===== design/sha256s_core.sv =====
// Round engine: one compression round per cycle over a shared round unit.
`default_nettype none
module sha256s_core (
   input  wire                          clock,
   input  wire                          reset,
   input  sha256s_pkg::core_ctrl_type   ctrl,
   input  sha256s_pkg::block_type       block,
   output sha256s_pkg::core_stat_type   stat,
   output sha256s_pkg::hash_type        chain
);

   localparam int unsigned RND_W = $clog2(sha256s_pkg::ROUNDS);

   sha256s_pkg::hash_type  chain_ff, chain_in;
   sha256s_pkg::hash_type  work_ff, work_in;
   sha256s_pkg::block_type sched_ff, sched_in;
   logic [RND_W-1:0]       round_ff, round_in;
   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;

   sha256s_pkg::word_type  t1, t2, w_next;
   sha256s_pkg::hash_type  round_out;

   // Shared round unit and schedule extension.
   always_comb begin
      t1 = work_ff[7] + sha256s_pkg::big_sigma1(work_ff[4])
         + ((work_ff[4] & work_ff[5]) ^ (~work_ff[4] & work_ff[6]))
         + sha256s_pkg::ROUND_K[round_ff] + sched_ff[0];
      t2 = sha256s_pkg::big_sigma0(work_ff[0])
         + ((work_ff[0] & work_ff[1]) ^ (work_ff[0] & work_ff[2])
            ^ (work_ff[1] & work_ff[2]));
      round_out[0] = t1 + t2;
      round_out[1] = work_ff[0];
      round_out[2] = work_ff[1];
      round_out[3] = work_ff[2];
      round_out[4] = work_ff[3] + t1;
      round_out[5] = work_ff[4];
      round_out[6] = work_ff[5];
      round_out[7] = work_ff[6];
      w_next = sched_ff[0] + sha256s_pkg::small_sigma0(sched_ff[1]) + sched_ff[9]
             + sha256s_pkg::small_sigma1(sched_ff[14]);
   end

   // Sequencing of the rounds and the final chaining update.
   always_comb begin
      chain_in = chain_ff;
      work_in  = work_ff;
      sched_in = sched_ff;
      round_in = round_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      if (ctrl.init) begin
         chain_in = sha256s_pkg::INIT_H;
      end else if (ctrl.start) begin
         work_in  = chain_ff;
         sched_in = block;
         round_in = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         work_in  = round_out;
         sched_in = {w_next, sched_ff[sha256s_pkg::BLOCK_WORDS-1:1]};
         round_in = round_ff + 1'b1;
         if (round_ff == RND_W'(sha256s_pkg::ROUNDS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            for (int i = 0; i < sha256s_pkg::HASH_WORDS; i++) begin
               chain_in[i] = chain_ff[i] + round_out[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= sha256s_pkg::INIT_H;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         round_ff <= '0;
      end else begin
         chain_ff <= chain_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         round_ff <= round_in;
      end
      work_ff  <= work_in;
      sched_ff <= sched_in;
   end

   assign stat.busy = busy_ff;
   assign stat.done = done_ff;
   assign chain     = chain_ff;

endmodule
`default_nettype wire
